FILE: hdl/mshw_pkg.sv
// Shared types, sizes and codes for the multi-slot heartbeat watchdog.
`timescale 1ns / 1ps

package mshw_pkg;

    localparam int SLOTS   = 32;
    localparam int BUCKETS = 16;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CD_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int BV_W    = $clog2(BUCKETS + 1);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    localparam int TASK_W  = 16;
    localparam int IVL_W   = 16;
    localparam int BASE_W  = 8;
    localparam int MAXP_W  = 12;
    localparam int ACC_W   = $clog2(BUCKETS * ((1 << BASE_W) - 1) + 1);

    localparam int IN_W    = TASK_W + IVL_W;
    localparam int OUT_RAW = 2 + 1 + TASK_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - OUT_RAW;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 12;

    localparam logic [BASE_W-1:0] BASE_RESET = 8'd5;
    localparam logic [MAXP_W-1:0] MAXP_RESET = 12'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_PERIOD = 1'b0,
        CFG_MAX_PERIOD  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_KICK       = 2'd2,
        REQ_TICK       = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_BAD_INTERVAL   = 2'd1,
        ST_SLOT_TAKEN     = 2'd2,
        ST_NOT_REGISTERED = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic walk_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic reg_go;
        logic tick_go;
        logic div_done;
        logic walk_last;
    } sts_t;

endpackage

FILE: hdl/mshw_ctrl.sv
// Sequencing state machine for the heartbeat watchdog.
`timescale 1ns / 1ps

module mshw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  mshw_pkg::sts_t sts,
    output mshw_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_WALK,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.exec = 1'b1;
                if (sts.reg_go) begin
                    state_next = S_DIV;
                end else if (sts.tick_go) begin
                    state_next = S_WALK;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = S_FIN;
                end
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

FILE: hdl/mshw_dp.sv
// Slot tables, bucket countdowns, interval divider and result register.
`timescale 1ns / 1ps

module mshw_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [mshw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mshw_pkg::CFG_W-1:0]      cfg_data,
    input  logic [1:0]                      in_req,
    input  logic [mshw_pkg::IN_W-1:0]       in_data,
    input  mshw_pkg::cmd_t                  cmd,
    output mshw_pkg::sts_t                  sts,
    output logic [mshw_pkg::OUT_W-1:0]      out_data
);

    logic [mshw_pkg::BASE_W-1:0] base_reg;
    logic [mshw_pkg::MAXP_W-1:0] maxp_reg;

    logic [mshw_pkg::TASK_W-1:0] slot_task_reg [mshw_pkg::SLOTS];
    logic [mshw_pkg::BV_W-1:0]   slot_bkt_reg  [mshw_pkg::SLOTS];
    logic [mshw_pkg::SLOTS-1:0]  slot_alive_reg;
    logic [mshw_pkg::CD_W-1:0]   cd_reg        [mshw_pkg::BUCKETS];
    logic [mshw_pkg::CNT_W-1:0]  count_reg;

    mshw_pkg::req_t              req_reg;
    logic [mshw_pkg::TASK_W-1:0] task_reg;
    logic [mshw_pkg::IVL_W-1:0]  ivl_reg;
    logic [mshw_pkg::ACC_W-1:0]  acc_reg;
    logic [mshw_pkg::CD_W-1:0]   k_reg;
    logic [mshw_pkg::SLOT_W-1:0] walk_ptr_reg;
    logic                        found_reg;
    logic [mshw_pkg::BV_W-1:0]   best_reg;
    logic [mshw_pkg::TASK_W-1:0] failed_reg;
    mshw_pkg::status_t           status_reg;
    logic [mshw_pkg::OUT_W-1:0]  out_reg;

    logic [mshw_pkg::BASE_W-1:0] base_eff;
    logic [mshw_pkg::SLOT_W-1:0] my_slot;
    logic                        occupied;
    logic                        bad_ivl;
    logic                        task_match;
    mshw_pkg::status_t           status_now;
    logic [mshw_pkg::ACC_W-1:0]  acc_sum;
    logic [mshw_pkg::BV_W-1:0]   new_bkt;
    logic [mshw_pkg::BV_W-1:0]   w_bkt;
    logic [mshw_pkg::CD_W-1:0]   w_cd_idx;
    logic                        w_due;
    logic                        w_better;

    assign base_eff   = (base_reg == '0) ? mshw_pkg::BASE_W'(1) : base_reg;
    assign my_slot    = task_reg[mshw_pkg::SLOT_W-1:0];
    assign occupied   = (slot_bkt_reg[my_slot] != '0);
    assign task_match = (slot_task_reg[my_slot] == task_reg);
    assign bad_ivl    = (ivl_reg < mshw_pkg::IVL_W'(base_eff))
                     || (ivl_reg > mshw_pkg::IVL_W'(maxp_reg));

    always_comb begin
        case (req_reg)
            mshw_pkg::REQ_REGISTER: begin
                if (bad_ivl) begin
                    status_now = mshw_pkg::ST_BAD_INTERVAL;
                end else if (occupied) begin
                    status_now = mshw_pkg::ST_SLOT_TAKEN;
                end else begin
                    status_now = mshw_pkg::ST_OK;
                end
            end
            mshw_pkg::REQ_UNREGISTER: begin
                status_now = occupied ? mshw_pkg::ST_OK : mshw_pkg::ST_NOT_REGISTERED;
            end
            mshw_pkg::REQ_KICK: begin
                status_now = (occupied && task_match) ? mshw_pkg::ST_OK
                                                      : mshw_pkg::ST_NOT_REGISTERED;
            end
            default: begin
                status_now = mshw_pkg::ST_OK;
            end
        endcase
    end

    // Ceiling division by repeated addition, capped at the bucket count
    assign acc_sum = acc_reg + mshw_pkg::ACC_W'(base_eff);
    assign new_bkt = mshw_pkg::BV_W'(k_reg) + mshw_pkg::BV_W'(1);

    // Slot walk on a tick
    assign w_bkt    = slot_bkt_reg[walk_ptr_reg];
    assign w_cd_idx = mshw_pkg::CD_W'(w_bkt - mshw_pkg::BV_W'(1));
    assign w_due    = (w_bkt != '0) && (cd_reg[w_cd_idx] == '0);
    assign w_better = !found_reg || (w_bkt < best_reg);

    assign sts.reg_go    = (req_reg == mshw_pkg::REQ_REGISTER) && !bad_ivl && !occupied;
    assign sts.tick_go   = (req_reg == mshw_pkg::REQ_TICK) && (count_reg != '0);
    assign sts.div_done  = (mshw_pkg::IVL_W'(acc_sum) >= ivl_reg)
                        || (k_reg == mshw_pkg::CD_W'(mshw_pkg::BUCKETS - 1));
    assign sts.walk_last = (walk_ptr_reg == mshw_pkg::SLOT_W'(mshw_pkg::SLOTS - 1));

    assign out_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= mshw_pkg::BASE_RESET;
            maxp_reg       <= mshw_pkg::MAXP_RESET;
            slot_alive_reg <= '0;
            count_reg      <= '0;
            for (int s = 0; s < mshw_pkg::SLOTS; s++) begin
                slot_task_reg[s] <= '0;
                slot_bkt_reg[s]  <= '0;
            end
            for (int b = 0; b < mshw_pkg::BUCKETS; b++) begin
                cd_reg[b] <= mshw_pkg::CD_W'(b);
            end
            req_reg      <= mshw_pkg::REQ_REGISTER;
            task_reg     <= '0;
            ivl_reg      <= '0;
            acc_reg      <= '0;
            k_reg        <= '0;
            walk_ptr_reg <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            failed_reg   <= '0;
            status_reg   <= mshw_pkg::ST_OK;
            out_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                case (mshw_pkg::cfg_idx_t'(cfg_index))
                    mshw_pkg::CFG_BASE_PERIOD: base_reg <= cfg_data[mshw_pkg::BASE_W-1:0];
                    mshw_pkg::CFG_MAX_PERIOD:  maxp_reg <= cfg_data[mshw_pkg::MAXP_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.load) begin
                req_reg      <= mshw_pkg::req_t'(in_req);
                task_reg     <= in_data[mshw_pkg::TASK_W-1:0];
                ivl_reg      <= in_data[mshw_pkg::IN_W-1:mshw_pkg::TASK_W];
                acc_reg      <= '0;
                k_reg        <= '0;
                walk_ptr_reg <= '0;
                found_reg    <= 1'b0;
                best_reg     <= '0;
                failed_reg   <= '0;
            end

            if (cmd.exec) begin
                status_reg <= status_now;
                if (req_reg == mshw_pkg::REQ_UNREGISTER && occupied) begin
                    slot_task_reg[my_slot]  <= '0;
                    slot_bkt_reg[my_slot]   <= '0;
                    slot_alive_reg[my_slot] <= 1'b0;
                    count_reg               <= count_reg - mshw_pkg::CNT_W'(1);
                end
                if (req_reg == mshw_pkg::REQ_KICK && occupied && task_match) begin
                    slot_alive_reg[my_slot] <= 1'b1;
                end
            end

            if (cmd.div_step) begin
                acc_reg <= acc_sum;
                k_reg   <= k_reg + mshw_pkg::CD_W'(1);
                if (sts.div_done) begin
                    slot_task_reg[my_slot]  <= task_reg;
                    slot_bkt_reg[my_slot]   <= new_bkt;
                    slot_alive_reg[my_slot] <= 1'b0;
                    count_reg               <= count_reg + mshw_pkg::CNT_W'(1);
                end
            end

            if (cmd.walk_step) begin
                walk_ptr_reg <= walk_ptr_reg + mshw_pkg::SLOT_W'(1);
                if (w_due) begin
                    if (slot_alive_reg[walk_ptr_reg]) begin
                        slot_alive_reg[walk_ptr_reg] <= 1'b0;
                    end else if (w_better) begin
                        found_reg  <= 1'b1;
                        best_reg   <= w_bkt;
                        failed_reg <= slot_task_reg[walk_ptr_reg];
                    end
                end
                if (sts.walk_last) begin
                    for (int b = 0; b < mshw_pkg::BUCKETS; b++) begin
                        if (cd_reg[b] == '0) begin
                            cd_reg[b] <= mshw_pkg::CD_W'(b);
                        end else begin
                            cd_reg[b] <= cd_reg[b] - mshw_pkg::CD_W'(1);
                        end
                    end
                end
            end

            if (cmd.out_load) begin
                out_reg <= {{mshw_pkg::OUT_PAD{1'b0}}, failed_reg, found_reg, status_reg};
            end
        end
    end

endmodule

FILE: hdl/multi_slot_heartbeat_watchdog_unit.sv
// Top level of the multi-slot heartbeat watchdog.
`timescale 1ns / 1ps
// Sequence: unregister, kick, rejected register and idle tick go from accept through decode to the result load;
//   accepted register: also runs the divider for n = ceil(interval / base period) capped at 16 (one add a cycle);
//   tick with slots registered: also runs the 32-slot walk, one slot a cycle.
// Flow: one item at a time; the next item is taken in the cycle after the result is loaded.
// Reset: aresetn synchronous active low; slots freed, countdowns set to their index, base period 5,
//   max period 60, output channel empty. No clearing pass is needed.

module multi_slot_heartbeat_watchdog_unit (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mshw_pkg::IN_W-1:0]      s_tdata,   // task_id[15:0], requested_interval[31:16]
    input  logic [1:0]                     s_tuser,   // req_type[1:0]

    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mshw_pkg::OUT_W-1:0]     m_tdata,   // status[1:0], system_reset[2],
                                                      // failed_task[18:3], zero[23:19]

    // Register writes: index 0 base_period, index 1 max_period
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mshw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mshw_pkg::CFG_W-1:0]     cfg_data
);

    mshw_pkg::cmd_t cmd;
    mshw_pkg::sts_t sts;

    // Writes go straight into the registers, so hold ready high
    assign cfg_ready = 1'b1;

    // Sequencer: accept, decode, run the divider or the slot walk, then load the result
    mshw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Slot state, bucket countdowns and the output register
    mshw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_req    (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata)
    );

endmodule
